FILE: hw/rtl/oets_pkg.sv
`timescale 1ns / 1ps

package oets_pkg;

  localparam int unsigned ValueW = 32;

  typedef logic signed [ValueW-1:0] value_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_EMIT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cell_op_e op;
    logic     act_left;
    logic     act_right;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/oets_cell.sv
`timescale 1ns / 1ps

module oets_cell (
  input  logic               clk_i,
  input  oets_pkg::cell_ctl_t ctl_i,
  input  oets_pkg::value_t   left_i,
  input  oets_pkg::value_t   right_i,
  input  logic               swap_left_i,
  output oets_pkg::value_t   value_o,
  output logic               gt_o
);

  oets_pkg::value_t value_q;
  oets_pkg::value_t value_d;

  assign gt_o    = value_q > right_i;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    unique case (ctl_i.op)
      oets_pkg::OP_HOLD: value_d = value_q;
      oets_pkg::OP_LOAD: value_d = left_i;
      oets_pkg::OP_EMIT: value_d = right_i;
      oets_pkg::OP_SORT: begin
        priority if (ctl_i.act_right && gt_o) begin
          value_d = right_i;
        end else if (ctl_i.act_left && swap_left_i) begin
          value_d = left_i;
        end else begin
          value_d = value_q;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: hw/rtl/odd_even_transposition_sort_core.sv
`timescale 1ns / 1ps

// Odd-even transposition sorter over a row of MAX_ITEMS cells.
// Input stream: s_axis_tdata carries one signed value per item, s_axis_tlast
// marks the final value of a set. Items beyond MAX_ITEMS are discarded and
// the whole set is then flagged on m_axis_tuser.
// Output stream: the set in ascending order, m_axis_tlast on the largest.
// Flow: load phase (one item per cycle while s_axis_tvalid is high, tready
// high), then n sort phases in the cell row for a set of n stored items, then
// n emit steps, each shifting the row toward cell 0 when an output item is
// accepted; the row compares all active pairs of a phase at once.
// m_axis_tvalid rises once the sort phases that follow the item marked last
// are done, and the first result can be accepted as soon as it is valid.
// Input tready is low while sorting and emitting; one set is in flight.
// When the receiver stalls, the row holds and the output item stays stable.
// Reset returns to loading with an empty row and the discard flag clear;
// cell contents are not cleared.
module odd_even_transposition_sort_core #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_res
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // [0] dropped
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  oets_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     phase_q, phase_d;
  logic                ovf_q, ovf_d;
  oets_pkg::cell_op_e  op;
  logic [MAX_ITEMS-1:0] pair_act;

  oets_pkg::value_t    cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_gt;

  logic in_acc;
  logic out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = state_q == oets_pkg::ST_LOAD;
  assign m_axis_tvalid = state_q == oets_pkg::ST_EMIT;
  assign m_axis_tdata  = cell_val[0];
  assign m_axis_tlast  = count_q == CntW'(1);
  assign m_axis_tuser  = ovf_q;

  always_comb begin
    for (int j = 0; j < MAX_ITEMS; j++) begin
      pair_act[j] = (1'(j) == phase_q[0]) && (CntW'(j + 1) < count_q);
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    phase_d = phase_q;
    ovf_d   = ovf_q;
    op      = oets_pkg::OP_HOLD;
    unique case (state_q)
      oets_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (count_q < CntW'(MAX_ITEMS)) begin
            op      = oets_pkg::OP_LOAD;
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = oets_pkg::ST_SORT;
            phase_d = '0;
          end
        end
      end
      oets_pkg::ST_SORT: begin
        op      = oets_pkg::OP_SORT;
        phase_d = phase_q + CntW'(1);
        if (phase_q == count_q - CntW'(1)) begin
          state_d = oets_pkg::ST_EMIT;
        end
      end
      oets_pkg::ST_EMIT: begin
        if (out_acc) begin
          op      = oets_pkg::OP_EMIT;
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            state_d = oets_pkg::ST_LOAD;
            ovf_d   = 1'b0;
          end
        end
      end
      default: state_d = oets_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oets_pkg::ST_LOAD;
      count_q <= '0;
      phase_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      ovf_q   <= ovf_d;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    oets_pkg::cell_ctl_t ctl;
    oets_pkg::value_t    left_val;
    oets_pkg::value_t    right_val;
    logic                swap_left;

    assign ctl.op = op;

    if (i == 0) begin : g_head
      assign left_val     = s_axis_tdata;
      assign swap_left    = 1'b0;
      assign ctl.act_left = 1'b0;
    end else begin : g_body
      assign left_val     = cell_val[i-1];
      assign swap_left    = cell_gt[i-1];
      assign ctl.act_left = pair_act[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_val     = '0;
      assign ctl.act_right = 1'b0;
    end else begin : g_mid
      assign right_val     = cell_val[i+1];
      assign ctl.act_right = pair_act[i];
    end

    oets_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .left_i      (left_val),
      .right_i     (right_val),
      .swap_left_i (swap_left),
      .value_o     (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> count_q != '0)
    else $error("emitting from an empty row");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("loading and emitting at once");

  a_last_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> state_q == oets_pkg::ST_SORT)
    else $error("set end did not start sorting");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> (s_axis_tready && count_q == '0 && !ovf_q))
    else $error("set end did not return to an empty row");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == oets_pkg::ST_SORT) |-> phase_q < count_q)
    else $error("sort phase count overran the set size");

endmodule
